>>> rtl/core/assert_macros.svh
// assertion helpers used by the checker file pmm_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/pmm_pkg.sv
`default_nettype none

package pmm_pkg;

    localparam int PAGE_TOTAL_DEF = 64;
    localparam int PAGE_BITS      = 8;
    localparam int PAGE_BYTES     = 1 << PAGE_BITS;
    localparam int ADDR_W         = 14;
    localparam int VPAGE_W        = ADDR_W - PAGE_BITS;
    localparam int DATA_W         = 8;
    localparam logic [DATA_W-1:0] PTR_BASE = 8'd64;
    localparam logic [DATA_W-1:0] LAST_OFF = 8'hff;

    typedef enum logic [1:0] {
        ACT_NEW   = 2'd0,
        ACT_KILL  = 2'd1,
        ACT_STORE = 2'd2,
        ACT_LOAD  = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP_RD,
        S_MAP_CHK,
        S_PTR_WR,
        S_ENT_WR,
        S_PTR_RD,
        S_PTR_CHK,
        S_K_RD,
        S_K_CHK,
        S_K_FREE,
        S_T_ENT,
        S_T_PHYS,
        S_T_DATA,
        S_T_LOAD
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

>>> rtl/core/paged_memory_manager_top.sv
`default_nettype none

// Paged memory manager over a PAGE_TOTAL x 256 byte memory with one write and
// one read port. After reset busy stays high for a clearing pass that zeroes
// the memory and marks page 0 in use. A word is taken when start is high and
// busy is low; busy then stays high until the result, which is shown for
// exactly one cycle with o_valid and must be captured then, since the receiver
// cannot stall it. Busy is already low in the cycle the result strobe is high,
// so the next word may start right away. Memory reads share the single read
// port and run one after another: a store or a load reads the pointer, then
// the table entry, then accesses the data, with the page wrap unit between
// reads; kill process reads and checks each table entry in turn, then frees
// the table page; new process reads and checks map bytes until a free one
// turns up, claims it for the pointer or for the next data page, and stops
// early when the map runs out.
module paged_memory_manager_top #(
    parameter int PAGE_TOTAL = pmm_pkg::PAGE_TOTAL_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_action,
    input  wire logic [5:0]                    i_proc_num,
    input  wire logic [7:0]                    i_page_count,
    input  wire logic [pmm_pkg::ADDR_W-1:0]    i_virt_addr,
    input  wire logic [pmm_pkg::DATA_W-1:0]    i_store_data,
    output logic                               o_valid,
    output logic                               o_status,
    output logic [7:0]                         o_failed_pages,
    output logic [pmm_pkg::ADDR_W-1:0]         o_xlat_addr,
    output logic [pmm_pkg::DATA_W-1:0]         o_load_data
);

    localparam int PG_W = $clog2(PAGE_TOTAL);

    pmm_pkg::t_mem_req          mem_req;
    logic [pmm_pkg::DATA_W-1:0] rd_data;
    logic [PG_W-1:0]            wrap_page;

    pmm_mem #(
        .PAGE_TOTAL (PAGE_TOTAL)
    ) u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    pmm_wrap #(
        .PAGE_TOTAL (PAGE_TOTAL)
    ) u_wrap (
        .i_page (rd_data),
        .o_page (wrap_page)
    );

    pmm_seq #(
        .PAGE_TOTAL (PAGE_TOTAL)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_action       (i_action),
        .i_proc_num     (i_proc_num),
        .i_page_count   (i_page_count),
        .i_virt_addr    (i_virt_addr),
        .i_store_data   (i_store_data),
        .o_mem_req      (mem_req),
        .i_rd_data      (rd_data),
        .i_wrap_page    (wrap_page),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_failed_pages (o_failed_pages),
        .o_xlat_addr    (o_xlat_addr),
        .o_load_data    (o_load_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/pmm_mem.sv
`default_nettype none

module pmm_mem #(
    parameter int PAGE_TOTAL = pmm_pkg::PAGE_TOTAL_DEF
) (
    input  wire logic                       i_clk,
    input  wire pmm_pkg::t_mem_req          i_req,
    output logic [pmm_pkg::DATA_W-1:0]      o_rd_data
);

    localparam int MEM_BYTES = PAGE_TOTAL * pmm_pkg::PAGE_BYTES;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    logic [pmm_pkg::DATA_W-1:0] r_mem [MEM_BYTES];
    logic [pmm_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[MEM_AW-1:0]] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr[MEM_AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/core/pmm_wrap.sv
`default_nettype none

// reduces a stored page number modulo the page count by restoring subtraction
module pmm_wrap #(
    parameter int PAGE_TOTAL = pmm_pkg::PAGE_TOTAL_DEF
) (
    input  wire logic [pmm_pkg::DATA_W-1:0]   i_page,
    output logic [$clog2(PAGE_TOTAL)-1:0]     o_page
);

    localparam int PG_W  = $clog2(PAGE_TOTAL);
    localparam int REM_W = pmm_pkg::DATA_W + 2;

    logic [REM_W-1:0] rem;

    // quotient is at most four bits since the page count is at least 16
    always_comb begin
        rem = {2'b00, i_page};
        for (int k = 3; k >= 0; k--) begin
            if (rem >= REM_W'(PAGE_TOTAL << k)) begin
                rem = rem - REM_W'(PAGE_TOTAL << k);
            end
        end
        o_page = rem[PG_W-1:0];
    end

endmodule

`default_nettype wire

>>> rtl/core/pmm_seq.sv
`default_nettype none

module pmm_seq #(
    parameter int PAGE_TOTAL = pmm_pkg::PAGE_TOTAL_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic [1:0]                          i_action,
    input  wire logic [5:0]                          i_proc_num,
    input  wire logic [7:0]                          i_page_count,
    input  wire logic [pmm_pkg::ADDR_W-1:0]          i_virt_addr,
    input  wire logic [pmm_pkg::DATA_W-1:0]          i_store_data,
    output pmm_pkg::t_mem_req                        o_mem_req,
    input  wire logic [pmm_pkg::DATA_W-1:0]          i_rd_data,
    input  wire logic [$clog2(PAGE_TOTAL)-1:0]       i_wrap_page,
    output logic                                     o_valid,
    output logic                                     o_status,
    output logic [7:0]                               o_failed_pages,
    output logic [pmm_pkg::ADDR_W-1:0]               o_xlat_addr,
    output logic [pmm_pkg::DATA_W-1:0]               o_load_data
);

    localparam int ADDR_W    = pmm_pkg::ADDR_W;
    localparam int DATA_W    = pmm_pkg::DATA_W;
    localparam int VPAGE_W   = pmm_pkg::VPAGE_W;
    localparam int PAGE_BITS = pmm_pkg::PAGE_BITS;
    localparam int PG_W      = $clog2(PAGE_TOTAL);
    localparam int PTR_W     = $clog2(PAGE_TOTAL + 1);
    localparam int MEM_BYTES = PAGE_TOTAL * pmm_pkg::PAGE_BYTES;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_BYTES - 1);
    localparam logic [PTR_W-1:0]  PTR_END   = PTR_W'(PAGE_TOTAL);
    localparam logic [DATA_W-1:0] PAGE_LIM  = DATA_W'(PAGE_TOTAL);

    pmm_pkg::t_state  r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_valid, n_valid;

    pmm_pkg::t_action  r_action, n_action;
    logic [5:0]        r_proc, n_proc;
    logic [7:0]        r_count, n_count;
    logic [ADDR_W-1:0] r_vaddr, n_vaddr;
    logic [DATA_W-1:0] r_sdata, n_sdata;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic              r_data_mode, n_data_mode;
    logic [PG_W-1:0]   r_page, n_page;
    logic [PG_W-1:0]   r_found, n_found;
    logic [DATA_W-1:0] r_traw, n_traw;
    logic [7:0]        r_idx, n_idx;
    logic [7:0]        r_off, n_off;
    logic              r_status, n_status;
    logic [7:0]        r_failed, n_failed;
    logic [ADDR_W-1:0] r_paddr, n_paddr;
    logic [DATA_W-1:0] r_ldata, n_ldata;

    logic [ADDR_W-1:0] ptr_addr;
    logic [ADDR_W-1:0] user_addr;
    logic              last_entry;

    assign ptr_addr   = ADDR_W'(pmm_pkg::PTR_BASE) + ADDR_W'(r_proc);
    assign user_addr  = {VPAGE_W'(r_page), r_vaddr[PAGE_BITS-1:0]};
    assign last_entry = (r_idx + 8'd1 == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pmm_pkg::S_CLEAR: begin
                if (r_clr == LAST_ADDR) begin
                    n_state = pmm_pkg::S_IDLE;
                end
            end
            pmm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_action == pmm_pkg::ACT_NEW) ? pmm_pkg::S_MAP_RD
                                                             : pmm_pkg::S_PTR_RD;
                end
            end
            pmm_pkg::S_MAP_RD: begin
                n_state = (r_ptr == PTR_END) ? pmm_pkg::S_IDLE : pmm_pkg::S_MAP_CHK;
            end
            pmm_pkg::S_MAP_CHK: begin
                if (i_rd_data != 8'd1) begin
                    n_state = r_data_mode ? pmm_pkg::S_ENT_WR : pmm_pkg::S_PTR_WR;
                end else begin
                    n_state = pmm_pkg::S_MAP_RD;
                end
            end
            pmm_pkg::S_PTR_WR: begin
                n_state = (r_count == 8'd0) ? pmm_pkg::S_IDLE : pmm_pkg::S_MAP_RD;
            end
            pmm_pkg::S_ENT_WR: begin
                n_state = last_entry ? pmm_pkg::S_IDLE : pmm_pkg::S_MAP_RD;
            end
            pmm_pkg::S_PTR_RD:  n_state = pmm_pkg::S_PTR_CHK;
            pmm_pkg::S_PTR_CHK: begin
                n_state = (r_action == pmm_pkg::ACT_KILL) ? pmm_pkg::S_K_RD
                                                          : pmm_pkg::S_T_ENT;
            end
            pmm_pkg::S_K_RD:    n_state = pmm_pkg::S_K_CHK;
            pmm_pkg::S_K_CHK: begin
                n_state = (r_off == pmm_pkg::LAST_OFF) ? pmm_pkg::S_K_FREE
                                                       : pmm_pkg::S_K_RD;
            end
            pmm_pkg::S_K_FREE:  n_state = pmm_pkg::S_IDLE;
            pmm_pkg::S_T_ENT:   n_state = pmm_pkg::S_T_PHYS;
            pmm_pkg::S_T_PHYS:  n_state = pmm_pkg::S_T_DATA;
            pmm_pkg::S_T_DATA: begin
                n_state = (r_action == pmm_pkg::ACT_STORE) ? pmm_pkg::S_IDLE
                                                           : pmm_pkg::S_T_LOAD;
            end
            pmm_pkg::S_T_LOAD:  n_state = pmm_pkg::S_IDLE;
            default:            n_state = pmm_pkg::S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_clr       = r_clr;
        n_valid     = 1'b0;
        n_action    = r_action;
        n_proc      = r_proc;
        n_count     = r_count;
        n_vaddr     = r_vaddr;
        n_sdata     = r_sdata;
        n_ptr       = r_ptr;
        n_data_mode = r_data_mode;
        n_page      = r_page;
        n_found     = r_found;
        n_traw      = r_traw;
        n_idx       = r_idx;
        n_off       = r_off;
        n_status    = r_status;
        n_failed    = r_failed;
        n_paddr     = r_paddr;
        n_ldata     = r_ldata;
        o_mem_req   = '0;
        case (r_state)
            pmm_pkg::S_CLEAR: begin
                // page 0 starts marked in use
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr;
                o_mem_req.wdata = (r_clr == '0) ? 8'd1 : 8'd0;
                n_clr           = r_clr + ADDR_W'(1);
            end
            pmm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_action    = pmm_pkg::t_action'(i_action);
                    n_proc      = i_proc_num;
                    n_count     = i_page_count;
                    n_vaddr     = i_virt_addr;
                    n_sdata     = i_store_data;
                    n_ptr       = PTR_W'(1);
                    n_data_mode = 1'b0;
                    n_idx       = 8'd0;
                end
            end
            pmm_pkg::S_MAP_RD: begin
                if (r_ptr == PTR_END) begin
                    // free map exhausted
                    n_valid  = 1'b1;
                    n_status = ~r_data_mode;
                    n_failed = r_data_mode ? (r_count - r_idx) : 8'd0;
                    n_paddr  = '0;
                    n_ldata  = '0;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = ADDR_W'(r_ptr);
                end
            end
            pmm_pkg::S_MAP_CHK: begin
                if (i_rd_data != 8'd1) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = ADDR_W'(r_ptr);
                    o_mem_req.wdata = 8'd1;
                    if (r_data_mode) begin
                        n_found = PG_W'(r_ptr);
                    end else begin
                        n_page = PG_W'(r_ptr);
                    end
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end
            pmm_pkg::S_PTR_WR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = ptr_addr;
                o_mem_req.wdata = DATA_W'(r_page);
                n_data_mode     = 1'b1;
                n_idx           = 8'd0;
                // pages below the table are all taken
                n_ptr           = PTR_W'(r_page) + PTR_W'(1);
                if (r_count == 8'd0) begin
                    n_valid  = 1'b1;
                    n_status = 1'b0;
                    n_failed = 8'd0;
                    n_paddr  = '0;
                    n_ldata  = '0;
                end
            end
            pmm_pkg::S_ENT_WR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = {VPAGE_W'(r_page), r_idx};
                o_mem_req.wdata = DATA_W'(r_found);
                n_idx           = r_idx + 8'd1;
                n_ptr           = PTR_W'(r_found) + PTR_W'(1);
                if (last_entry) begin
                    n_valid  = 1'b1;
                    n_status = 1'b0;
                    n_failed = 8'd0;
                    n_paddr  = '0;
                    n_ldata  = '0;
                end
            end
            pmm_pkg::S_PTR_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = ptr_addr;
            end
            pmm_pkg::S_PTR_CHK: begin
                n_traw = i_rd_data;
                n_page = i_wrap_page;
                n_off  = 8'd0;
            end
            pmm_pkg::S_K_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = {VPAGE_W'(r_page), r_off};
            end
            pmm_pkg::S_K_CHK: begin
                // write lands before the next entry read, so a walk of page 0 sees it
                if (i_rd_data != 8'd0 && i_rd_data < PAGE_LIM) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = ADDR_W'(i_rd_data);
                    o_mem_req.wdata = 8'd0;
                end
                n_off = r_off + 8'd1;
            end
            pmm_pkg::S_K_FREE: begin
                if (r_traw < PAGE_LIM) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = ADDR_W'(r_traw);
                    o_mem_req.wdata = 8'd0;
                end
                n_valid  = 1'b1;
                n_status = 1'b0;
                n_failed = 8'd0;
                n_paddr  = '0;
                n_ldata  = '0;
            end
            pmm_pkg::S_T_ENT: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = {VPAGE_W'(r_page),
                                   PAGE_BITS'(r_vaddr[ADDR_W-1:PAGE_BITS])};
            end
            pmm_pkg::S_T_PHYS: begin
                n_page = i_wrap_page;
            end
            pmm_pkg::S_T_DATA: begin
                n_paddr = user_addr;
                if (r_action == pmm_pkg::ACT_STORE) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = user_addr;
                    o_mem_req.wdata = r_sdata;
                    n_valid         = 1'b1;
                    n_status        = 1'b0;
                    n_failed        = 8'd0;
                    n_ldata         = '0;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = user_addr;
                end
            end
            pmm_pkg::S_T_LOAD: begin
                n_valid  = 1'b1;
                n_status = 1'b0;
                n_failed = 8'd0;
                n_ldata  = i_rd_data;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmm_pkg::S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_proc      <= n_proc;
        r_count     <= n_count;
        r_vaddr     <= n_vaddr;
        r_sdata     <= n_sdata;
        r_ptr       <= n_ptr;
        r_data_mode <= n_data_mode;
        r_page      <= n_page;
        r_found     <= n_found;
        r_traw      <= n_traw;
        r_idx       <= n_idx;
        r_off       <= n_off;
        r_status    <= n_status;
        r_failed    <= n_failed;
        r_paddr     <= n_paddr;
        r_ldata     <= n_ldata;
    end

    assign o_busy         = (r_state != pmm_pkg::S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_failed_pages = r_failed;
    assign o_xlat_addr    = r_paddr;
    assign o_load_data    = r_ldata;

endmodule

`default_nettype wire

>>> rtl/core/pmm_checker.sv
`default_nettype none

`include "assert_macros.svh"

module pmm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_valid,
    input wire logic                          o_status,
    input wire logic [7:0]                    o_failed_pages,
    input wire logic [pmm_pkg::ADDR_W-1:0]    o_xlat_addr,
    input wire logic [pmm_pkg::DATA_W-1:0]    o_load_data
);

    // an accepted word makes the block busy
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)

    // the result shows up as the block goes idle
    `ASSERT_IMPLY(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)

    // every operation passes through more than one state after idle, so strobes never touch
    `ASSERT_NEXT(a_valid_gap, i_clk, i_rst_n, o_valid, !o_valid)

    // a table allocation failure reports nothing else
    `ASSERT_IMPLY(a_status_clean, i_clk, i_rst_n, o_valid && o_status,
        o_failed_pages == 8'd0 && o_xlat_addr == '0 && o_load_data == '0)

endmodule

bind paged_memory_manager_top pmm_checker u_pmm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_failed_pages (o_failed_pages),
    .o_xlat_addr    (o_xlat_addr),
    .o_load_data    (o_load_data)
);

`default_nettype wire

>>> dv/pmm_result_checker.sv
`timescale 1ns / 1ps

module pmm_result_checker #(
    parameter int PAGE_TOTAL = pmm_pkg::PAGE_TOTAL_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [1:0]                 i_action,
    input  logic [5:0]                 i_proc_num,
    input  logic [7:0]                 i_page_count,
    input  logic [pmm_pkg::ADDR_W-1:0] i_virt_addr,
    input  logic [pmm_pkg::DATA_W-1:0] i_store_data,
    input  logic                       i_valid,
    input  logic                       i_status,
    input  logic [7:0]                 i_failed_pages,
    input  logic [pmm_pkg::ADDR_W-1:0] i_xlat_addr,
    input  logic [pmm_pkg::DATA_W-1:0] i_load_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_compared,
    output int                         o_table_oom,
    output int                         o_short_alloc
);

    localparam int ADDR_W     = pmm_pkg::ADDR_W;
    localparam int DATA_W     = pmm_pkg::DATA_W;
    localparam int PAGE_BITS  = pmm_pkg::PAGE_BITS;
    localparam int PAGE_BYTES = pmm_pkg::PAGE_BYTES;
    localparam int MEM_BYTES  = PAGE_TOTAL * PAGE_BYTES;
    localparam int NO_PAGE    = 255;

    typedef struct packed {
        logic              status;
        logic [7:0]        failed_pages;
        logic [ADDR_W-1:0] xlat_addr;
        logic [DATA_W-1:0] load_data;
    } t_step_reply;

    logic [DATA_W-1:0] shadow_mem [MEM_BYTES];
    t_step_reply       reply_q [$];
    int                mismatches = 0;
    int                compared = 0;
    int                oom_words = 0;
    int                short_words = 0;

    function automatic int page_addr(input int page, input int offset);
        return ((page << PAGE_BITS) | (offset & 'hff)) % MEM_BYTES;
    endfunction

    function automatic int ptr_addr(input int proc);
        return (int'(pmm_pkg::PTR_BASE) + (proc & 'h3f)) % MEM_BYTES;
    endfunction

    // lowest page from 1 whose map byte is not exactly one
    function automatic int claim_free_page();
        for (int i = 1; i < PAGE_TOTAL; i++) begin
            if (shadow_mem[i] != 8'd1) begin
                shadow_mem[i] = 8'd1;
                return i;
            end
        end
        return NO_PAGE;
    endfunction

    function automatic void release_page(input int page);
        if (page < PAGE_TOTAL)
            shadow_mem[page] = '0;
    endfunction

    function automatic int translate_addr(input int proc, input int vaddr);
        int tbl;
        int frame;
        tbl   = shadow_mem[ptr_addr(proc)];
        frame = shadow_mem[page_addr(tbl, (vaddr >> PAGE_BITS) & 'h3f)];
        return page_addr(frame, vaddr & 'hff);
    endfunction

    function automatic t_step_reply run_step(input pmm_pkg::t_action act, input int proc,
                                             input int cnt, input int vaddr,
                                             input logic [7:0] data);
        t_step_reply r;
        int          tbl;
        int          pg;
        int          entry;
        r = '0;
        case (act)
            pmm_pkg::ACT_NEW: begin
                tbl = claim_free_page();
                if (tbl == NO_PAGE) begin
                    r.status = 1'b1;
                end else begin
                    shadow_mem[ptr_addr(proc)] = 8'(tbl);
                    for (int i = 0; i < cnt; i++) begin
                        pg = claim_free_page();
                        if (pg == NO_PAGE)
                            r.failed_pages = r.failed_pages + 8'd1;
                        else
                            shadow_mem[page_addr(tbl, i)] = 8'(pg);
                    end
                end
            end
            pmm_pkg::ACT_KILL: begin
                // walk is in order, so a table at page 0 sees its own freed bytes
                tbl = shadow_mem[ptr_addr(proc)];
                for (int off = 0; off < PAGE_BYTES; off++) begin
                    entry = shadow_mem[page_addr(tbl, off)];
                    if (entry != 0)
                        release_page(entry);
                end
                release_page(tbl);
            end
            pmm_pkg::ACT_STORE: begin
                r.xlat_addr = ADDR_W'(translate_addr(proc, vaddr));
                shadow_mem[int'(r.xlat_addr)] = data;
            end
            default: begin
                r.xlat_addr = ADDR_W'(translate_addr(proc, vaddr));
                r.load_data = shadow_mem[int'(r.xlat_addr)];
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_step_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_BYTES; i++)
                shadow_mem[i] = '0;
            shadow_mem[0] = 8'd1;
            reply_q.delete();
        end else begin
            if (i_valid === 1'b1) begin
                if (reply_q.size() == 0) begin
                    $error("result word with no request outstanding");
                    mismatches++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", 16'(want.status), 16'(i_status));
                    check_field("failed_pages", 16'(want.failed_pages), 16'(i_failed_pages));
                    check_field("xlat_addr", 16'(want.xlat_addr), 16'(i_xlat_addr));
                    check_field("load_data", 16'(want.load_data), 16'(i_load_data));
                    compared++;
                end
            end
            if (i_start && i_busy === 1'b0) begin
                want = run_step(pmm_pkg::t_action'(i_action), int'(i_proc_num),
                                int'(i_page_count), int'(i_virt_addr), i_store_data);
                reply_q.push_back(want);
                if (want.status)
                    oom_words++;
                if (want.failed_pages != 0)
                    short_words++;
            end
        end
        o_fail_count  <= mismatches;
        o_pending     <= reply_q.size();
        o_compared    <= compared;
        o_table_oom   <= oom_words;
        o_short_alloc <= short_words;
    end

endmodule

>>> dv/paged_memory_manager_top_tb.sv
`timescale 1ns / 1ps

module paged_memory_manager_top_tb;

    localparam int STALL_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 1500;
    localparam int ADDR_W       = pmm_pkg::ADDR_W;
    localparam int DATA_W       = pmm_pkg::DATA_W;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic [1:0]          i_action = '0;
    logic [5:0]          i_proc_num = '0;
    logic [7:0]          i_page_count = '0;
    logic [ADDR_W-1:0]   i_virt_addr = '0;
    logic [DATA_W-1:0]   i_store_data = '0;
    logic                busy;
    logic                o_valid;
    logic                o_status;
    logic [7:0]          o_failed_pages;
    logic [ADDR_W-1:0]   o_xlat_addr;
    logic [DATA_W-1:0]   o_load_data;

    int fail_count;
    int pending;
    int compared;
    int table_oom;
    int short_alloc;
    int stall_cycles = 0;
    int words_by_action [4] = '{0, 0, 0, 0};

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    paged_memory_manager_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_proc_num     (i_proc_num),
        .i_page_count   (i_page_count),
        .i_virt_addr    (i_virt_addr),
        .i_store_data   (i_store_data),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_failed_pages (o_failed_pages),
        .o_xlat_addr    (o_xlat_addr),
        .o_load_data    (o_load_data)
    );

    pmm_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_proc_num     (i_proc_num),
        .i_page_count   (i_page_count),
        .i_virt_addr    (i_virt_addr),
        .i_store_data   (i_store_data),
        .i_valid        (o_valid),
        .i_status       (o_status),
        .i_failed_pages (o_failed_pages),
        .i_xlat_addr    (o_xlat_addr),
        .i_load_data    (o_load_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_compared     (compared),
        .o_table_oom    (table_oom),
        .o_short_alloc  (short_alloc)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid === 1'b1 || (start && busy === 1'b0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("paged_memory_manager_top_tb failed");
        $finish;
    end

    // start stays high from word to word unless a gap is inserted
    task automatic issue_word(input pmm_pkg::t_action act, input logic [5:0] proc,
                              input logic [7:0] cnt, input logic [ADDR_W-1:0] vaddr,
                              input logic [DATA_W-1:0] data);
        start        <= 1'b1;
        i_action     <= act;
        i_proc_num   <= proc;
        i_page_count <= cnt;
        i_virt_addr  <= vaddr;
        i_store_data <= data;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        words_by_action[act]++;
    endtask

    initial begin
        pmm_pkg::t_action  act;
        logic [5:0]        proc;
        logic [7:0]        cnt;
        logic [ADDR_W-1:0] vaddr;
        int                pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing allocated yet: table pointer is zero, lookup lands in the map
        issue_word(pmm_pkg::ACT_LOAD, 6'd0, 8'd0, 14'd0, 8'd0);
        issue_word(pmm_pkg::ACT_NEW, 6'd0, 8'd0, 14'd0, 8'd0);
        // runs out of data pages partway through
        issue_word(pmm_pkg::ACT_NEW, 6'd63, 8'd255, 14'd0, 8'd0);
        // no page left for a table
        issue_word(pmm_pkg::ACT_NEW, 6'd5, 8'd3, 14'd0, 8'd0);
        issue_word(pmm_pkg::ACT_STORE, 6'd63, 8'd0, 14'h3fff, 8'hff);
        issue_word(pmm_pkg::ACT_LOAD, 6'd63, 8'd0, 14'h3fff, 8'd0);
        issue_word(pmm_pkg::ACT_STORE, 6'd63, 8'hff, 14'd0, 8'h00);
        issue_word(pmm_pkg::ACT_STORE, 6'd63, 8'd0, {6'd10, 8'h80}, 8'h5a);
        issue_word(pmm_pkg::ACT_LOAD, 6'd63, 8'd0, {6'd10, 8'h80}, 8'd0);
        // unused process maps onto page 1, i.e. the table of process 0:
        // plant an entry beyond the memory so the next load wraps
        issue_word(pmm_pkg::ACT_STORE, 6'd9, 8'd0, {6'd0, 8'd5}, 8'd200);
        issue_word(pmm_pkg::ACT_LOAD, 6'd0, 8'd0, {6'd5, 8'hff}, 8'd0);
        issue_word(pmm_pkg::ACT_KILL, 6'd63, 8'd0, 14'd0, 8'd0);
        // entry 200 is out of range and must be skipped
        issue_word(pmm_pkg::ACT_KILL, 6'd0, 8'd0, 14'd0, 8'd0);
        // table pointer zero: the walk runs over the free map itself
        issue_word(pmm_pkg::ACT_KILL, 6'd9, 8'd0, 14'd0, 8'd0);
        issue_word(pmm_pkg::ACT_NEW, 6'd1, 8'd4, 14'd0, 8'd0);
        issue_word(pmm_pkg::ACT_STORE, 6'd1, 8'd0, {6'd2, 8'h33}, 8'hc3);
        issue_word(pmm_pkg::ACT_LOAD, 6'd1, 8'd0, {6'd2, 8'h33}, 8'd0);
        issue_word(pmm_pkg::ACT_NEW, 6'd62, 8'd128, 14'd0, 8'd0);
        issue_word(pmm_pkg::ACT_KILL, 6'd1, 8'd0, 14'd0, 8'd0);
        issue_word(pmm_pkg::ACT_LOAD, 6'd62, 8'd0, {6'd1, 8'h00}, 8'd0);
        issue_word(pmm_pkg::ACT_KILL, 6'd62, 8'd0, 14'd0, 8'd0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if ((n < 600 || n >= 900) && $urandom_range(0, 99) < 18) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 20)
                act = pmm_pkg::ACT_NEW;
            else if (pick < 33)
                act = pmm_pkg::ACT_KILL;
            else if (pick < 65)
                act = pmm_pkg::ACT_STORE;
            else
                act = pmm_pkg::ACT_LOAD;
            // a small pool of processes keeps tables live between words
            proc = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7))
                                               : 6'($urandom_range(0, 63));
            // big allocations scan the whole map per page, so keep them rare
            cnt = ($urandom_range(0, 149) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 12));
            vaddr = ($urandom_range(0, 99) < 85)
                    ? {6'($urandom_range(0, 12)), 8'($urandom_range(0, 255))}
                    : ADDR_W'($urandom_range(0, 16383));
            issue_word(act, proc, cnt, vaddr, 8'($urandom_range(0, 255)));
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("words sent: %0d new, %0d kill, %0d store, %0d load; %0d results compared",
                 words_by_action[pmm_pkg::ACT_NEW], words_by_action[pmm_pkg::ACT_KILL],
                 words_by_action[pmm_pkg::ACT_STORE], words_by_action[pmm_pkg::ACT_LOAD],
                 compared);
        $display("new process hit a full map %0d times, fell short on data pages %0d times",
                 table_oom, short_alloc);
        if (fail_count == 0 && pending == 0)
            $display("paged_memory_manager_top_tb passed");
        else
            $display("paged_memory_manager_top_tb failed");
        $finish;
    end

endmodule
